[rtl/core/fss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Fuzzy subsequence scorer package
// Shared types, register indexes, scoring constants and character helpers.
// -----------------------------------------------------------------------------
package fss_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int QLEN_W      = 6;
    localparam int SCORE_W     = 18;
    localparam int SCORE_OUT_W = 17;
    localparam int BONUS_W     = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_CHARS0 = 3'd1;

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = -18'sd65536;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 18'sd65535;
    localparam logic signed [SCORE_W-1:0] SCORE_MISS = -18'sd1;

    localparam logic [BONUS_W-1:0] BONUS_BOUNDARY = 5'd16;
    localparam logic [BONUS_W-1:0] BONUS_CAMEL    = 5'd8;
    localparam logic [BONUS_W-1:0] BONUS_RUN      = 5'd4;

    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DASH       = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    typedef struct packed {
        logic [QLEN_W-1:0]         matched_count;
        logic signed [SCORE_W-1:0] score;
        logic [7:0]                prev_char;
        logic                      prev_matched;
        logic                      at_start;
    } t_text_state;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
    endfunction

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        return is_upper(c) ? c + CASE_OFFSET : c;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_SLASH) || (c == CH_UNDERSCORE) || (c == CH_DASH) ||
               (c == CH_DOT) || (c == CH_SPACE);
    endfunction

endpackage
`default_nettype wire

[rtl/core/fss_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Fuzzy subsequence scorer step
// Next text state for one character: match test, bonus and saturating score.
// -----------------------------------------------------------------------------
module fss_step
    import fss_pkg::*;
(
    input  wire t_text_state       i_state,
    input  wire logic [7:0]        i_char,
    input  wire logic              i_present,
    input  wire logic [7:0]        i_query_char,
    input  wire logic [QLEN_W-1:0] i_qlen,
    output t_text_state            o_state,
    output logic                   o_complete
);

    logic                      active;
    logic                      hit;
    logic [BONUS_W-1:0]        bonus;
    logic signed [SCORE_W-1:0] delta;
    logic signed [SCORE_W-1:0] sum;

    always_comb begin
        active = i_present && (i_state.matched_count < i_qlen);
        hit    = fold_lower(i_char) == fold_lower(i_query_char);

        bonus = '0;
        if (i_state.at_start || is_sep(i_state.prev_char)) begin
            bonus = BONUS_BOUNDARY;
        end else if (is_lower(i_state.prev_char) && is_upper(i_char)) begin
            bonus = BONUS_CAMEL;
        end
        if (i_state.prev_matched) begin
            bonus = bonus + BONUS_RUN;
        end

        delta = hit ? $signed({{(SCORE_W-BONUS_W){1'b0}}, bonus}) : SCORE_MISS;
        sum   = i_state.score + delta;
        if (sum < SCORE_MIN) begin
            sum = SCORE_MIN;
        end else if (sum > SCORE_MAX) begin
            sum = SCORE_MAX;
        end

        o_state = i_state;
        if (active) begin
            o_state.score        = sum;
            o_state.prev_matched = hit;
            o_state.prev_char    = i_char;
            o_state.at_start     = 1'b0;
            if (hit) begin
                o_state.matched_count = i_state.matched_count + 1'b1;
            end
        end
        o_complete = o_state.matched_count >= i_qlen;
    end

endmodule
`default_nettype wire

[rtl/core/fuzzy_subsequence_scorer.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Fuzzy subsequence scorer
// Scores a stream of text bytes against a configured case-insensitive query.
//
// Text bytes enter on the input channel (i_in_valid / o_in_ready), one per
// transaction. A transaction with i_in_last_of_text set closes the text and
// produces one result transaction on the output channel (o_out_valid /
// i_out_ready) carrying score, matched and too_long; all other transactions
// produce no output.
// An accepted byte sits in an input register while it is scored; a closing
// byte then loads the result register as it leaves the input register, and
// the result is held there until it is taken. One byte is accepted every
// cycle; the input stalls only when a closing byte is waiting and the result
// register is still full and not being taken. Non-closing bytes keep flowing
// while a result waits. The query is loaded through the write port (i_cfg_we,
// i_cfg_index, i_cfg_data); the user must do so only while no text is in
// flight, which the block itself does not enforce.
// Reset clears the query, the text state and both pipeline valid flags.
// -----------------------------------------------------------------------------
module fuzzy_subsequence_scorer
    import fss_pkg::*;
#(
    parameter int MAX_QUERY_LEN = 32,
    parameter int POSITION_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [7:0]             i_in_text_char,
    input  wire logic                   i_in_char_present,
    input  wire logic                   i_in_last_of_text,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic signed [SCORE_OUT_W-1:0] o_out_score,
    output logic                        o_out_matched,
    output logic                        o_out_too_long
);

    localparam int QIDX_W = (MAX_QUERY_LEN > 1) ? $clog2(MAX_QUERY_LEN) : 1;

    logic [QLEN_W-1:0]        r_qlen;
    logic [7:0]               r_query [MAX_QUERY_LEN];
    logic [QLEN_W-1:0]        qlen_eff;

    logic                     r_in_valid;
    logic [7:0]               r_char;
    logic                     r_present;
    logic                     r_last;
    logic                     advance;

    t_text_state              r_state;
    t_text_state              n_state;
    logic                     complete;
    logic [POSITION_BITS-1:0] r_pos;
    logic                     r_overflow;
    logic                     n_overflow;
    logic                     pos_full;

    logic                     r_out_valid;
    logic signed [SCORE_OUT_W-1:0] r_out_score;
    logic                     r_out_matched;
    logic                     r_out_too_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= '0;
        end else if (i_cfg_we && (i_cfg_index == REG_QUERY_LENGTH)) begin
            r_qlen <= i_cfg_data[QLEN_W-1:0];
        end
    end

    for (genvar k = 0; k < MAX_QUERY_LEN; k++) begin : g_query
        localparam logic [CFG_INDEX_W-1:0] REG_IDX =
            REG_QUERY_CHARS0 + CFG_INDEX_W'(k / 8);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_query[k] <= '0;
            end else if (i_cfg_we && (i_cfg_index == REG_IDX)) begin
                r_query[k] <= i_cfg_data[8*(k%8) +: 8];
            end
        end
    end

    assign qlen_eff = (r_qlen > QLEN_W'(MAX_QUERY_LEN)) ? QLEN_W'(MAX_QUERY_LEN) : r_qlen;

    assign advance    = r_in_valid && (!r_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char    <= i_in_text_char;
            r_present <= i_in_char_present;
            r_last    <= i_in_last_of_text;
        end
    end

    fss_step u_step (
        .i_state      (r_state),
        .i_char       (r_char),
        .i_present    (r_present),
        .i_query_char (r_query[r_state.matched_count[QIDX_W-1:0]]),
        .i_qlen       (qlen_eff),
        .o_state      (n_state),
        .o_complete   (complete)
    );

    assign pos_full   = &r_pos;
    assign n_overflow = r_overflow || (r_present && pos_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= '{default: '0, at_start: 1'b1};
            r_pos      <= '0;
            r_overflow <= 1'b0;
        end else if (advance) begin
            if (r_last) begin
                r_state    <= '{default: '0, at_start: 1'b1};
                r_pos      <= '0;
                r_overflow <= 1'b0;
            end else begin
                r_state    <= n_state;
                r_overflow <= n_overflow;
                if (r_present && !pos_full) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_out_score    <= complete ? n_state.score[SCORE_OUT_W-1:0] : '1;
            r_out_matched  <= complete;
            r_out_too_long <= n_overflow;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_score    = r_out_score;
    assign o_out_matched  = r_out_matched;
    assign o_out_too_long = r_out_too_long;

endmodule
`default_nettype wire
